// ===== rtl/lru_pkg.sv =====
package lru_pkg;

    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 10;
    localparam int RANK_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FIDX_W    = 2;
    localparam int EVP_W     = 10;
    localparam int FAULT_W   = 16;

    localparam logic [RANK_W-1:0]  RANK_MRU  = RANK_W'(FRAMES - 1);
    localparam logic [RANK_W-1:0]  RANK_LRU  = '0;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [RANK_W-1:0]    rank_t;

    // priority chain running from frame 0 upward
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
    } lru_chain_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic  update;
        logic  hit_any;
        logic  empty_any;
        rank_t old_rank;
        page_t page;
    } lru_ctl_t;

    // what each cell reports back
    typedef struct packed {
        logic  sel;
        rank_t rank;
        page_t page;
    } lru_stat_t;

endpackage

// ===== rtl/lru_req_if.sv =====
interface lru_req_if import lru_pkg::*; ();
    logic  valid;
    logic  ready;
    page_t page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

// ===== rtl/lru_rsp_if.sv =====
interface lru_rsp_if import lru_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIDX_W-1:0]  frame_index;
    logic               evicted_valid;
    logic [EVP_W-1:0]   evicted_page;
    logic [FAULT_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

// ===== rtl/lru_cell.sv =====
module lru_cell import lru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rank_t      cell_idx,
    input  lru_ctl_t   ctl,
    input  lru_chain_t chain_in,
    output lru_chain_t chain_out,
    output lru_stat_t  stat
);

    logic  valid_reg;
    logic  valid_next;
    rank_t rank_reg;
    rank_t rank_next;
    page_t page_reg;
    page_t page_next;
    logic  match;
    logic  first_hit;
    logic  first_empty;
    logic  sel;

    assign match       = valid_reg && (page_reg == ctl.page);
    assign first_hit   = match && !chain_in.hit_seen;
    assign first_empty = !valid_reg && !chain_in.empty_seen;

    assign chain_out.hit_seen   = chain_in.hit_seen || match;
    assign chain_out.empty_seen = chain_in.empty_seen || !valid_reg;

    always_comb
    begin
        if (ctl.hit_any)
        begin
            sel = first_hit;
        end
        else if (ctl.empty_any)
        begin
            sel = first_empty;
        end
        else
        begin
            sel = (rank_reg == RANK_LRU);
        end
    end

    assign stat.sel  = sel;
    assign stat.rank = rank_reg;
    assign stat.page = page_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        page_next  = page_reg;
        if (ctl.update)
        begin
            if (sel)
            begin
                rank_next = RANK_MRU;
                if (!ctl.hit_any)
                begin
                    valid_next = 1'b1;
                    page_next  = ctl.page;
                end
            end
            else if (rank_reg > ctl.old_rank)
            begin
                rank_next = rank_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= cell_idx;
            page_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            page_reg  <= page_next;
        end
    end

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// channel | dir | payload
// req     | in  | page_number
// rsp     | out | hit, frame_index, evicted_valid, evicted_page, fault_total
//
// One reference per cycle: the row of frame cells looks up, picks the frame
// and updates its ranks in the cycle the beat is taken; the result is
// registered. req.ready drops only while a result waits and rsp.ready is low.
// Reset empties all frames, sets ranks to index order and clears the fault count.
module lru_page_replacement_top import lru_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    lru_req_if.sink      req,
    lru_rsp_if.source    rsp
);

    lru_chain_t chain [FRAMES+1];
    lru_stat_t  stat  [FRAMES];
    lru_ctl_t   ctl;
    logic       accept;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               hit_reg;
    logic [FIDX_W-1:0]  fidx_reg;
    logic               ev_valid_reg;
    logic [EVP_W-1:0]   ev_page_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic [FAULT_W-1:0] fault_next;

    rank_t              old_rank;
    page_t              sel_page;
    logic [FIDX_W-1:0]  sel_idx;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign chain[0] = '0;

    assign ctl.update    = accept;
    assign ctl.hit_any   = chain[FRAMES].hit_seen;
    assign ctl.empty_any = chain[FRAMES].empty_seen;
    assign ctl.old_rank  = old_rank;
    assign ctl.page      = req.page_number;

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lru_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (RANK_W'(g)),
            .ctl       (ctl),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g])
        );
    end

    always_comb
    begin
        old_rank = '0;
        sel_page = '0;
        sel_idx  = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (stat[i].sel)
            begin
                old_rank = old_rank | stat[i].rank;
                sel_page = sel_page | stat[i].page;
                sel_idx  = sel_idx | FIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        fault_next = fault_reg;
        if (accept && !ctl.hit_any && (fault_reg != FAULT_MAX))
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fault_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= ctl.hit_any;
            fidx_reg     <= sel_idx;
            ev_valid_reg <= !ctl.hit_any && !ctl.empty_any;
            ev_page_reg  <= (!ctl.hit_any && !ctl.empty_any) ? EVP_W'(sel_page) : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.frame_index   = fidx_reg;
    assign rsp.evicted_valid = ev_valid_reg;
    assign rsp.evicted_page  = ev_page_reg;
    assign rsp.fault_total   = fault_reg;

endmodule
